// ===== design/rmsm_pkg.sv =====
package rmsm_pkg;

  localparam int RAW_W   = 32;
  localparam int MAG_W   = 18;
  localparam int CNT_W   = 11;
  localparam int SUM_W   = 45;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int QUOT_W  = 35;
  localparam int LEVEL_W = 18;
  localparam int RAD_W   = 2 * LEVEL_W;

  localparam int SAMPLE_SHIFT = 14;
  localparam int COUNT_LIMIT  = 2047;
  localparam int BLOCK_MAX_DEF = 1024;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(1 << 17);

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             counted;
    logic             ignored;
    logic             last;
  } entry_t;

  typedef enum logic [1:0] {
    BK_POP,
    BK_ADD,
    BK_FINISH,
    BK_SOLVE
  } bk_state_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_SQRT
  } rt_state_t;

endpackage

// ===== design/rmsm_front.sv =====
module rmsm_front #(
  parameter int BLOCK_MAX = rmsm_pkg::BLOCK_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       full,
  input  logic [rmsm_pkg::RAW_W-1:0] raw_sample,
  input  logic                       last_sample,
  output logic                       push,
  output rmsm_pkg::entry_t           entry
);

  localparam int WordLimit =
    (BLOCK_MAX < rmsm_pkg::COUNT_LIMIT) ? BLOCK_MAX : rmsm_pkg::COUNT_LIMIT;

  logic [rmsm_pkg::CNT_W-1:0] words_r, words_nxt;
  logic [rmsm_pkg::MAG_W-1:0] field;
  logic                       ignored;

  assign push    = start && !full;
  assign ignored = words_r >= rmsm_pkg::CNT_W'(WordLimit);
  assign field   = raw_sample[rmsm_pkg::RAW_W-1:rmsm_pkg::SAMPLE_SHIFT];

  always_comb begin
    entry.mag     = field[rmsm_pkg::MAG_W-1] ? (~field + 1'b1) : field;
    entry.counted = !ignored && (raw_sample != '1);
    entry.ignored = ignored;
    entry.last    = last_sample;
  end

  always_comb begin
    words_nxt = words_r;
    if (push) begin
      if (last_sample) begin
        words_nxt = '0;
      end else if (!ignored) begin
        words_nxt = words_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
    end else begin
      words_r <= words_nxt;
    end
  end

endmodule

// ===== design/rmsm_queue.sv =====
module rmsm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rmsm_pkg::entry_t push_entry,
  input  logic             pop,
  output rmsm_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  localparam int Depth = rmsm_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  rmsm_pkg::entry_t    slot_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     fill_r;

  assign full  = fill_r == CntW'(Depth);
  assign empty = fill_r == '0;
  assign head  = slot_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ===== design/rmsm_root.sv =====
module rmsm_root (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [rmsm_pkg::SUM_W-1:0]   dividend,
  input  logic [rmsm_pkg::CNT_W-1:0]   divisor,
  output logic                         done,
  output logic [rmsm_pkg::LEVEL_W-1:0] level
);

  localparam int SUM_W   = rmsm_pkg::SUM_W;
  localparam int CNT_W   = rmsm_pkg::CNT_W;
  localparam int LEVEL_W = rmsm_pkg::LEVEL_W;
  localparam int RAD_W   = rmsm_pkg::RAD_W;
  localparam int SREM_W  = LEVEL_W + 2;
  localparam int StepW   = $clog2(SUM_W);

  rmsm_pkg::rt_state_t state_r, state_nxt;
  logic [StepW-1:0]    step_r, step_nxt;
  logic [CNT_W-1:0]    div_r;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [RAD_W-1:0]    rad_r;
  logic [SREM_W-1:0]   srem_r, srem_nxt;
  logic [LEVEL_W-1:0]  root_r, root_nxt;
  logic                done_r;

  // restoring divide, one quotient bit a cycle
  logic [CNT_W:0]      rem_sh, rem_diff;
  logic                q_bit;
  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign q_bit    = rem_sh >= {1'b0, div_r};
  assign rem_nxt  = q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign quo_nxt  = {quo_r[SUM_W-2:0], q_bit};

  // digit-by-digit square root, one result bit a cycle
  logic [SREM_W+1:0]   srem_sh, trial, srem_diff;
  logic                r_bit;
  assign srem_sh   = {srem_r, rad_r[RAD_W-1 -: 2]};
  assign trial     = (SREM_W + 2)'({root_r, 2'b01});
  assign srem_diff = srem_sh - trial;
  assign r_bit     = srem_sh >= trial;
  assign srem_nxt  = r_bit ? srem_diff[SREM_W-1:0] : srem_sh[SREM_W-1:0];
  assign root_nxt  = {root_r[LEVEL_W-2:0], r_bit};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      rmsm_pkg::RT_IDLE: begin
        if (go) begin
          state_nxt = rmsm_pkg::RT_DIV;
          step_nxt  = '0;
        end
      end
      rmsm_pkg::RT_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(SUM_W - 1)) begin
          state_nxt = rmsm_pkg::RT_SQRT;
          step_nxt  = '0;
        end
      end
      rmsm_pkg::RT_SQRT: begin
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(LEVEL_W - 1)) begin
          state_nxt = rmsm_pkg::RT_IDLE;
          step_nxt  = '0;
        end
      end
      default: begin
        state_nxt = rmsm_pkg::RT_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmsm_pkg::RT_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= (state_r == rmsm_pkg::RT_SQRT) && (step_r == StepW'(LEVEL_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rmsm_pkg::RT_IDLE: begin
        if (go) begin
          div_r <= divisor;
          quo_r <= dividend;
          rem_r <= '0;
        end
      end
      rmsm_pkg::RT_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        if (step_r == StepW'(SUM_W - 1)) begin
          // mean square is at most 2^34, upper quotient bits are zero
          rad_r  <= RAD_W'(quo_nxt[rmsm_pkg::QUOT_W-1:0]);
          srem_r <= '0;
          root_r <= '0;
        end
      end
      rmsm_pkg::RT_SQRT: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        srem_r <= srem_nxt;
        root_r <= root_nxt;
      end
      default: begin
        root_r <= root_r;
      end
    endcase
  end

  assign done  = done_r;
  assign level = root_r;

endmodule

// ===== design/rmsm_back.sv =====
module rmsm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rmsm_pkg::entry_t             head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         out_valid,
  output logic [rmsm_pkg::LEVEL_W-1:0] out_rms_level,
  output logic [rmsm_pkg::CNT_W-1:0]   out_valid_count,
  output logic                         out_block_overflow
);

  localparam int SUM_W = rmsm_pkg::SUM_W;
  localparam int CNT_W = rmsm_pkg::CNT_W;

  rmsm_pkg::bk_state_t              state_r, state_nxt;
  logic [rmsm_pkg::SQ_W-1:0]        sq_r, prod;
  logic                             counted_r, ignored_r, last_r;
  logic [SUM_W-1:0]                 sum_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic                             ovf_r;
  logic                             root_go, root_done;
  logic [rmsm_pkg::LEVEL_W-1:0]     root_level;
  logic                             emit, emit_zero;
  logic                             out_valid_r;
  logic [rmsm_pkg::LEVEL_W-1:0]     level_r;
  logic [CNT_W-1:0]                 count_r;
  logic                             ovf_out_r;

  assign prod = head.mag * head.mag;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    root_go   = 1'b0;
    emit      = 1'b0;
    emit_zero = 1'b0;
    case (state_r)
      rmsm_pkg::BK_POP: begin
        if (!empty) begin
          pop       = 1'b1;
          state_nxt = rmsm_pkg::BK_ADD;
        end
      end
      rmsm_pkg::BK_ADD: begin
        state_nxt = last_r ? rmsm_pkg::BK_FINISH : rmsm_pkg::BK_POP;
      end
      rmsm_pkg::BK_FINISH: begin
        if (cnt_r == '0) begin
          emit      = 1'b1;
          emit_zero = 1'b1;
          state_nxt = rmsm_pkg::BK_POP;
        end else begin
          root_go   = 1'b1;
          state_nxt = rmsm_pkg::BK_SOLVE;
        end
      end
      rmsm_pkg::BK_SOLVE: begin
        if (root_done) begin
          emit      = 1'b1;
          state_nxt = rmsm_pkg::BK_POP;
        end
      end
      default: state_nxt = rmsm_pkg::BK_POP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmsm_pkg::BK_POP;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (state_r == rmsm_pkg::BK_ADD) begin
        if (counted_r) begin
          sum_r <= sum_r + SUM_W'(sq_r);
          cnt_r <= cnt_r + 1'b1;
        end
        ovf_r <= ovf_r | ignored_r;
      end
      if (emit) begin
        sum_r <= '0;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sq_r      <= prod;
      counted_r <= head.counted;
      ignored_r <= head.ignored;
      last_r    <= head.last;
    end
    if (emit) begin
      level_r   <= emit_zero ? '0 : root_level;
      count_r   <= cnt_r;
      ovf_out_r <= ovf_r;
    end
  end

  rmsm_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (root_go),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (root_done),
    .level    (root_level)
  );

  assign out_valid          = out_valid_r;
  assign out_rms_level      = level_r;
  assign out_valid_count    = count_r;
  assign out_block_overflow = ovf_out_r;

endmodule

// ===== design/audio_block_rms_meter_top.sv =====
// The back end adds each word before its next pop; the 4-beat queue takes bursts at 1 per cycle while not full.
// busy is high while the queue is full, mostly during the end-of-block solve.
// After the last word of a block the back end pops, adds and finishes it, then runs the 45-step divide
// and the 18-step root before out_valid; with no valid samples, finish emits a zero level with no solve.
// Synchronous active-low reset clears the word count, queue, accumulators and out_valid.
module audio_block_rms_meter_top #(
  parameter int BLOCK_MAX = rmsm_pkg::BLOCK_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rmsm_pkg::RAW_W-1:0]   in_raw_sample,
  input  logic                         in_last_sample,
  output logic                         out_valid,
  output logic [rmsm_pkg::LEVEL_W-1:0] out_rms_level,
  output logic [rmsm_pkg::CNT_W-1:0]   out_valid_count,
  output logic                         out_block_overflow
);

  rmsm_pkg::entry_t push_entry, head;
  logic             push, pop, full, empty;

  assign busy = full;

  rmsm_front #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .full        (full),
    .raw_sample  (in_raw_sample),
    .last_sample (in_last_sample),
    .push        (push),
    .entry       (push_entry)
  );

  rmsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  rmsm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .empty              (empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_rms_level      (out_rms_level),
    .out_valid_count    (out_valid_count),
    .out_block_overflow (out_block_overflow)
  );

endmodule

// ===== design/rmsm_checker.sv =====
module rmsm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [rmsm_pkg::LEVEL_W-1:0] out_rms_level,
  input logic [rmsm_pkg::CNT_W-1:0]   out_valid_count
);

  // no result comes out of reset, and the queue starts empty
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("result or busy right after reset");

  // results are spaced by at least the accumulate and finish steps
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in adjacent cycles");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rms_level <= rmsm_pkg::LEVEL_MAX))
    else $error("rms level above full scale");

  a_empty_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_valid_count == '0)) |-> (out_rms_level == '0))
    else $error("nonzero level with no valid samples");

  // the queue never fills from empty in one beat
  a_busy_needs_traffic: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

endmodule

bind audio_block_rms_meter_top rmsm_checker u_rmsm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_rms_level   (out_rms_level),
  .out_valid_count (out_valid_count)
);

// ===== dv/tb.sv =====
module tb;
  import rmsm_pkg::*;

  localparam int BLOCK_WORDS = BLOCK_MAX_DEF;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [RAW_W-1:0] INVALID_WORD = '1;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [CNT_W-1:0]   count;
    logic               overflow;
  } block_level_t;

  class rms_scoreboard;
    logic [SUM_W-1:0] square_sum;
    logic [CNT_W-1:0] valid_samples;
    logic [CNT_W-1:0] words_seen;
    logic             overflow_seen;
    block_level_t     expected_levels[$];
    int               errors;
    int               words_noted;
    int               blocks_closed;
    int               overflow_blocks;
    int               empty_blocks;

    function new();
      clear_block();
      errors = 0;
      words_noted = 0;
      blocks_closed = 0;
      overflow_blocks = 0;
      empty_blocks = 0;
    endfunction

    function void clear_block();
      square_sum = '0;
      valid_samples = '0;
      words_seen = '0;
      overflow_seen = 1'b0;
    endfunction

    // truncating square root, bit pair at a time
    function logic [LEVEL_W-1:0] floor_root(logic [SUM_W-1:0] value);
      logic [47:0] rem;
      logic [47:0] root;
      logic [47:0] probe;
      rem = 48'(value);
      root = '0;
      probe = 48'd1 << 46;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem = rem - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root[LEVEL_W-1:0];
    endfunction

    function void note_input(logic [RAW_W-1:0] word, logic last);
      logic [MAG_W-1:0] field;
      logic [MAG_W-1:0] mag;
      block_level_t     res;
      words_noted++;
      if (words_seen >= BLOCK_WORDS || words_seen >= COUNT_LIMIT) begin
        overflow_seen = 1'b1;
      end else begin
        words_seen++;
        if (word != INVALID_WORD) begin
          field = word[RAW_W-1:SAMPLE_SHIFT];
          mag = field[MAG_W-1] ? MAG_W'(-field) : field;
          square_sum += SUM_W'(mag) * SUM_W'(mag);
          valid_samples++;
        end
      end
      if (last) begin
        res.level = (valid_samples == 0) ? '0 : floor_root(square_sum / valid_samples);
        res.count = valid_samples;
        res.overflow = overflow_seen;
        expected_levels.push_back(res);
        blocks_closed++;
        if (overflow_seen) overflow_blocks++;
        if (valid_samples == 0) empty_blocks++;
        clear_block();
      end
    endfunction

    function void check_result(logic [LEVEL_W-1:0] level, logic [CNT_W-1:0] count,
                               logic overflow);
      block_level_t exp_res;
      if (expected_levels.size() == 0) begin
        $error("unexpected result beat: rms_level %0d valid_count %0d block_overflow %0d",
               level, count, overflow);
        errors++;
        return;
      end
      exp_res = expected_levels.pop_front();
      if (level !== exp_res.level) begin
        $error("rms_level: expected %0d, actual %0d", exp_res.level, level);
        errors++;
      end
      if (count !== exp_res.count) begin
        $error("valid_count: expected %0d, actual %0d", exp_res.count, count);
        errors++;
      end
      if (overflow !== exp_res.overflow) begin
        $error("block_overflow: expected %0d, actual %0d", exp_res.overflow, overflow);
        errors++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [RAW_W-1:0]   in_raw_sample;
  logic               in_last_sample;
  logic               out_valid;
  logic [LEVEL_W-1:0] out_rms_level;
  logic [CNT_W-1:0]   out_valid_count;
  logic               out_block_overflow;

  rms_scoreboard sb = new();
  bit            no_idle;
  int            cycle_count = 0;

  audio_block_rms_meter_top #(.BLOCK_MAX(BLOCK_WORDS)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_raw_sample     (in_raw_sample),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_rms_level     (out_rms_level),
    .out_valid_count   (out_valid_count),
    .out_block_overflow(out_block_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_rms_level, out_valid_count, out_block_overflow);
    end
  end

  // start stays high across back-to-back beats; it only drops ahead of a gap
  task automatic send_word(input logic [RAW_W-1:0] word, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_raw_sample <= word;
    in_last_sample <= last;
    do @(posedge clk); while (busy);
    sb.note_input(word, last);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [RAW_W-1:0] pick_word();
    int unsigned sel;
    logic [MAG_W-1:0] field;
    sel = $urandom_range(0, 99);
    if (sel < 10) return INVALID_WORD;
    if (sel < 20) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFE;
        default: return 32'h0000_3FFF;
      endcase
    end
    if (sel < 40) begin
      // quiet signal: small field either side of zero, random low bits
      field = MAG_W'($urandom_range(0, 64)) - MAG_W'(32);
      return {field, 14'($urandom)};
    end
    return $urandom;
  endfunction

  task automatic send_block(input int len, input bit all_invalid);
    for (int i = 0; i < len; i++) begin
      send_word(all_invalid ? INVALID_WORD : pick_word(), i == len - 1);
    end
  endtask

  initial begin
    int random_words;
    int len;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_raw_sample <= '0;
    in_last_sample <= 1'b0;
    no_idle = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, lone words, empty blocks, mixed content
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(INVALID_WORD, 1'b1);
    send_word(INVALID_WORD, 1'b0);
    send_word(INVALID_WORD, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h0000_4000, 1'b0);
    send_word(32'hFFFF_C000, 1'b0);
    send_word(32'hFFFF_FFFE, 1'b0);
    send_word(32'h0000_3FFF, 1'b1);
    send_word(INVALID_WORD, 1'b0);
    send_word(INVALID_WORD, 1'b0);
    send_word(INVALID_WORD, 1'b1);
    no_idle = 1'b1;
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(INVALID_WORD, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h5555_5555, 1'b1);
    no_idle = 1'b0;
    wait_drained();

    // full block at full scale that then runs past the block size
    for (int i = 0; i < BLOCK_WORDS + 6; i++) begin
      no_idle = (i < BLOCK_WORDS);
      send_word((i < BLOCK_WORDS) ? 32'h8000_0000 : pick_word(), i == BLOCK_WORDS + 5);
    end
    no_idle = 1'b0;
    wait_drained();

    random_words = 0;
    while (random_words < 150) begin
      no_idle = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
      send_block(len, $urandom_range(0, 11) == 0);
      random_words += len;
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words in %0d blocks: %0d overran the block size, %0d had no valid samples.",
             sb.words_noted, sb.blocks_closed, sb.overflow_blocks, sb.empty_blocks);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
